@@ hdl/sbmp_pkg.sv @@
// Shared types, codes and helpers for the backend message parser.
// No dependencies; every other file of the block but sbmp_in_reg imports this package.
`default_nettype none

package sbmp_pkg;

    // Result classes carried on item_class.
    localparam logic [3:0] CLS_TYPE      = 4'd0;
    localparam logic [3:0] CLS_LENGTH    = 4'd1;
    localparam logic [3:0] CLS_COLCOUNT  = 4'd2;
    localparam logic [3:0] CLS_COLLENGTH = 4'd3;
    localparam logic [3:0] CLS_COLVALUE  = 4'd4;
    localparam logic [3:0] CLS_COLNAME   = 4'd5;
    localparam logic [3:0] CLS_COLATTR   = 4'd6;
    localparam logic [3:0] CLS_FIELDCODE = 4'd7;
    localparam logic [3:0] CLS_STRING    = 4'd8;
    localparam logic [3:0] CLS_FIXED     = 4'd9;
    localparam logic [3:0] CLS_IGNORED   = 4'd10;

    // Message type letters.
    localparam logic [7:0] MSG_DATA_ROW    = 8'h44; // 'D'
    localparam logic [7:0] MSG_ROW_DESC    = 8'h54; // 'T'
    localparam logic [7:0] MSG_ERROR       = 8'h45; // 'E'
    localparam logic [7:0] MSG_NOTICE      = 8'h4E; // 'N'
    localparam logic [7:0] MSG_NOTIFY      = 8'h41; // 'A'
    localparam logic [7:0] MSG_CMD_DONE    = 8'h43; // 'C'
    localparam logic [7:0] MSG_READY       = 8'h5A; // 'Z'
    localparam logic [7:0] MSG_KEY_DATA    = 8'h4B; // 'K'
    localparam logic [7:0] MSG_AUTH        = 8'h52; // 'R'
    localparam logic [7:0] MSG_PARAM_STAT  = 8'h53; // 'S'
    localparam logic [7:0] STATUS_IDLE     = 8'h49; // 'I'

    localparam logic [31:0] NULL_LENGTH    = 32'hFFFF_FFFF;
    localparam logic [31:0] HEADER_LENGTH  = 32'd4;
    localparam logic [7:0]  ATTR_LAST_OFF  = 8'd17;  // 18-byte attribute block
    localparam logic [7:0]  F4_LAST_OFF    = 8'd3;
    localparam logic [7:0]  OFFSET_MAX     = 8'd255;

    typedef enum logic [2:0] {
        KIND_NONE,
        KIND_F4,
        KIND_F1,
        KIND_STR,
        KIND_REST
    } kind_t;

    typedef struct packed {
        logic [7:0]  msg_type;
        logic [3:0]  item_class;
        logic [7:0]  data_byte;
        logic [15:0] column_index;
        logic [7:0]  field_offset;
        logic [7:0]  field_code;
        logic        end_of_field;
        logic        end_of_message;
        logic        null_column;
        logic        ready_idle;
        logic        length_error;
    } result_t;

    // Layout of the simple message bodies: kind of the k-th field.
    function automatic kind_t field_kind(input logic [7:0] t, input logic [31:0] k);
        kind_t kind;
        kind = KIND_NONE;
        unique case (t)
            MSG_NOTIFY:     kind = (k == 32'd0) ? KIND_F4 :
                                   ((k <= 32'd2) ? KIND_STR : KIND_NONE);
            MSG_KEY_DATA:   kind = (k <= 32'd1) ? KIND_F4 : KIND_NONE;
            MSG_PARAM_STAT: kind = (k <= 32'd1) ? KIND_STR : KIND_NONE;
            MSG_CMD_DONE:   kind = (k == 32'd0) ? KIND_STR : KIND_NONE;
            MSG_AUTH:       kind = (k == 32'd0) ? KIND_F4 :
                                   ((k == 32'd1) ? KIND_REST : KIND_NONE);
            MSG_READY:      kind = (k == 32'd0) ? KIND_F1 : KIND_NONE;
            default:        kind = KIND_NONE;
        endcase
        return kind;
    endfunction

endpackage

`default_nettype wire

@@ hdl/sbmp_in_reg.sv @@
// Input register of the message parser: holds one received byte.
// Self-contained; it uses nothing from the other files of the block.
`default_nettype none

module sbmp_in_reg
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       rx_valid,
    output logic            rx_stall,
    input  wire logic [7:0] rx_byte,
    input  wire logic       take,
    output logic            held_valid,
    output logic [7:0]      held_byte
);
    logic       valid_reg;
    logic [7:0] byte_reg;

    // The register is free when empty or when its byte moves on this cycle.
    assign rx_stall   = valid_reg && !take;
    assign held_valid = valid_reg;
    assign held_byte  = byte_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (rx_valid && !rx_stall)
        begin
            valid_reg <= 1'b1;
        end
        else if (take)
        begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx_valid && !rx_stall)
        begin
            byte_reg <= rx_byte;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sbmp_parser.sv @@
// Parse state and the single-pass classification of one byte.
// Depends on sbmp_pkg for result_t, class codes, type letters and field_kind.
`default_nettype none

module sbmp_parser
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              step,
    input  wire logic [7:0]        in_byte,
    output sbmp_pkg::result_t      result
);
    import sbmp_pkg::*;

    typedef enum logic [3:0] {
        PH_TYPE,
        PH_LEN,
        PH_COUNT,
        PH_COLLEN,
        PH_COLVAL,
        PH_NAME,
        PH_ATTR,
        PH_CODE,
        PH_STRING,
        PH_FIXED,
        PH_REST,
        PH_IGNORE
    } phase_t;

    phase_t      phase_reg,    phase_next;
    logic [7:0]  type_reg,     type_next;
    logic [31:0] remain_reg,   remain_next;
    logic [31:0] shift_reg,    shift_next;
    logic [31:0] sub_reg,      sub_next;
    logic [15:0] cols_reg,     cols_next;
    logic [15:0] colnum_reg,   colnum_next;
    logic [7:0]  ecode_reg,    ecode_next;
    logic [7:0]  offset_reg,   offset_next;

    logic        last;
    logic        do_next_col;
    logic        do_start;
    logic        do_clear;
    logic [31:0] start_k;
    logic [31:0] shifted;
    logic [31:0] sub_dec;
    kind_t       start_kind;
    logic        is_error_msg;

    always_comb
    begin
        phase_next  = phase_reg;
        type_next   = type_reg;
        remain_next = remain_reg;
        shift_next  = shift_reg;
        sub_next    = sub_reg;
        cols_next   = cols_reg;
        colnum_next = colnum_reg;
        ecode_next  = ecode_reg;
        offset_next = offset_reg;

        result            = '0;
        result.data_byte  = in_byte;
        result.item_class = CLS_IGNORED;

        last        = 1'b0;
        do_next_col = 1'b0;
        do_start    = 1'b0;
        do_clear    = 1'b0;
        start_k     = sub_reg + 32'd1;
        shifted     = {shift_reg[23:0], in_byte};
        sub_dec     = sub_reg - 32'd1;
        is_error_msg = (type_reg == MSG_ERROR) || (type_reg == MSG_NOTICE);

        unique case (phase_reg)
            PH_TYPE:
            begin
                type_next         = in_byte;
                result.item_class = CLS_TYPE;
                do_clear          = 1'b1;
            end
            PH_LEN:
            begin
                result.item_class   = CLS_LENGTH;
                result.field_offset = offset_reg;
                shift_next          = shifted;
                if (offset_reg >= F4_LAST_OFF)
                begin
                    if (shifted <= HEADER_LENGTH)
                    begin
                        result.length_error   = (shifted < HEADER_LENGTH);
                        result.end_of_message = 1'b1;
                        do_clear              = 1'b1;
                    end
                    else
                    begin
                        remain_next = shifted - HEADER_LENGTH;
                        offset_next = '0;
                        shift_next  = '0;
                        ecode_next  = '0;
                        if ((type_reg == MSG_DATA_ROW) || (type_reg == MSG_ROW_DESC))
                        begin
                            phase_next = PH_COUNT;
                        end
                        else if (is_error_msg)
                        begin
                            phase_next = PH_CODE;
                        end
                        else
                        begin
                            do_start = 1'b1;
                            start_k  = '0;
                        end
                    end
                end
                else
                begin
                    offset_next = offset_reg + 8'd1;
                end
            end
            default:
            begin
                remain_next = remain_reg - 32'd1;
                last        = (remain_reg == 32'd1);
                unique case (phase_reg)
                    PH_COUNT:
                    begin
                        result.item_class   = CLS_COLCOUNT;
                        result.field_offset = offset_reg;
                        shift_next          = shifted;
                        if (offset_reg >= 8'd1)
                        begin
                            result.end_of_field = 1'b1;
                            cols_next   = shifted[15:0];
                            colnum_next = '0;
                            offset_next = '0;
                            shift_next  = '0;
                            if (shifted[15:0] == 16'd0)
                            begin
                                phase_next = PH_IGNORE;
                            end
                            else
                            begin
                                phase_next = (type_reg == MSG_DATA_ROW) ? PH_COLLEN : PH_NAME;
                            end
                        end
                        else
                        begin
                            offset_next = offset_reg + 8'd1;
                        end
                    end
                    PH_COLLEN:
                    begin
                        result.item_class   = CLS_COLLENGTH;
                        result.column_index = colnum_reg;
                        result.field_offset = offset_reg;
                        shift_next          = shifted;
                        if (offset_reg >= F4_LAST_OFF)
                        begin
                            if (shifted == NULL_LENGTH)
                            begin
                                result.null_column  = 1'b1;
                                result.end_of_field = 1'b1;
                                do_next_col         = 1'b1;
                            end
                            else if (shifted == 32'd0)
                            begin
                                result.end_of_field = 1'b1;
                                do_next_col         = 1'b1;
                            end
                            else
                            begin
                                sub_next   = shifted;
                                phase_next = PH_COLVAL;
                            end
                        end
                        else
                        begin
                            offset_next = offset_reg + 8'd1;
                        end
                    end
                    PH_COLVAL:
                    begin
                        result.item_class   = CLS_COLVALUE;
                        result.column_index = colnum_reg;
                        sub_next            = sub_dec;
                        if (sub_dec == 32'd0)
                        begin
                            result.end_of_field = 1'b1;
                            do_next_col         = 1'b1;
                        end
                    end
                    PH_NAME:
                    begin
                        result.item_class   = CLS_COLNAME;
                        result.column_index = colnum_reg;
                        if (in_byte == 8'd0)
                        begin
                            result.end_of_field = 1'b1;
                            offset_next         = '0;
                            phase_next          = PH_ATTR;
                        end
                    end
                    PH_ATTR:
                    begin
                        result.item_class   = CLS_COLATTR;
                        result.column_index = colnum_reg;
                        result.field_offset = offset_reg;
                        if (offset_reg >= ATTR_LAST_OFF)
                        begin
                            result.end_of_field = 1'b1;
                            do_next_col         = 1'b1;
                        end
                        else
                        begin
                            offset_next = offset_reg + 8'd1;
                        end
                    end
                    PH_CODE:
                    begin
                        result.item_class = CLS_FIELDCODE;
                        result.field_code = in_byte;
                        ecode_next        = in_byte;
                        phase_next        = (in_byte == 8'd0) ? PH_IGNORE : PH_STRING;
                    end
                    PH_STRING:
                    begin
                        result.item_class = CLS_STRING;
                        result.field_code = ecode_reg;
                        if (in_byte == 8'd0)
                        begin
                            result.end_of_field = 1'b1;
                            if (is_error_msg)
                            begin
                                phase_next = PH_CODE;
                            end
                            else
                            begin
                                do_start = 1'b1;
                            end
                        end
                    end
                    PH_FIXED:
                    begin
                        result.item_class   = CLS_FIXED;
                        result.field_offset = offset_reg;
                        result.ready_idle   = (type_reg == MSG_READY) && (in_byte == STATUS_IDLE);
                        if ((field_kind(type_reg, sub_reg) == KIND_F1)
                            || (offset_reg >= F4_LAST_OFF))
                        begin
                            result.end_of_field = 1'b1;
                            do_start            = 1'b1;
                        end
                        else
                        begin
                            offset_next = offset_reg + 8'd1;
                        end
                    end
                    PH_REST:
                    begin
                        result.item_class   = CLS_FIXED;
                        result.field_offset = offset_reg;
                        result.end_of_field = last;
                        if (offset_reg != OFFSET_MAX)
                        begin
                            offset_next = offset_reg + 8'd1;
                        end
                    end
                    default:
                    begin
                        result.item_class = CLS_IGNORED;
                    end
                endcase
            end
        endcase

        // Advance to the next column of a data row or row description.
        if (do_next_col)
        begin
            cols_next   = cols_reg - 16'd1;
            colnum_next = colnum_reg + 16'd1;
            offset_next = '0;
            shift_next  = '0;
            if (cols_reg == 16'd1)
            begin
                phase_next = PH_IGNORE;
            end
            else
            begin
                phase_next = (type_reg == MSG_DATA_ROW) ? PH_COLLEN : PH_NAME;
            end
        end

        // Open the next field of a simple message body.
        start_kind = field_kind(type_reg, start_k);
        if (do_start)
        begin
            sub_next    = start_k;
            offset_next = '0;
            unique case (start_kind)
                KIND_F4, KIND_F1: phase_next = PH_FIXED;
                KIND_STR:         phase_next = PH_STRING;
                KIND_REST:        phase_next = PH_REST;
                default:          phase_next = PH_IGNORE;
            endcase
        end

        if (last)
        begin
            result.end_of_message = 1'b1;
            do_clear              = 1'b1;
        end

        if (do_clear)
        begin
            phase_next  = (phase_reg == PH_TYPE) ? PH_LEN : PH_TYPE;
            remain_next = '0;
            shift_next  = '0;
            sub_next    = '0;
            cols_next   = '0;
            colnum_next = '0;
            ecode_next  = '0;
            offset_next = '0;
        end

        result.msg_type = type_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= PH_TYPE;
            type_reg   <= '0;
            remain_reg <= '0;
            shift_reg  <= '0;
            sub_reg    <= '0;
            cols_reg   <= '0;
            colnum_reg <= '0;
            ecode_reg  <= '0;
            offset_reg <= '0;
        end
        else if (step)
        begin
            phase_reg  <= phase_next;
            type_reg   <= type_next;
            remain_reg <= remain_next;
            shift_reg  <= shift_next;
            sub_reg    <= sub_next;
            cols_reg   <= cols_next;
            colnum_reg <= colnum_next;
            ecode_reg  <= ecode_next;
            offset_reg <= offset_next;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sbmp_out_reg.sv @@
// Result register of the message parser: holds one classified byte.
// Depends on sbmp_pkg for result_t.
`default_nettype none

module sbmp_out_reg
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              load_valid,
    input  sbmp_pkg::result_t      load_data,
    output logic                   can_load,
    output logic                   res_valid,
    input  wire logic              res_stall,
    output sbmp_pkg::result_t      res_data
);
    import sbmp_pkg::*;

    logic    valid_reg;
    result_t data_reg;

    // Free when empty or when the held result is taken this cycle.
    assign can_load  = !valid_reg || !res_stall;
    assign res_valid = valid_reg;
    assign res_data  = data_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (can_load)
        begin
            valid_reg <= load_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (can_load && load_valid)
        begin
            data_reg <= load_data;
        end
    end

endmodule

`default_nettype wire

@@ hdl/sql_backend_message_parser.sv @@
// Backend message parser: frames and classifies a received byte stream.
// Path: input register, then the parse logic, then the result register.
// Throughput: one byte per cycle, held back only by stalls on the result side.
// The rate is set by the single-pass parse logic between the input and
// result registers; the parse state updates once per byte.
// Reset (rst_n low, asynchronous) empties both registers and awaits a type byte.
`default_nettype none

// Structure:
//   sbmp_in_reg  - one-byte input register on the rx channel.
//   sbmp_parser  - message state (phase, lengths, column counters, field
//                  code) and the combinational step that classifies the
//                  held byte and computes the next state.
//   sbmp_out_reg - result register on the res channel.
// A byte moves from the input register through the parser into the result
// register whenever the result register is empty or its result is being
// taken in the same cycle, so a new request is accepted every cycle as long
// as the consumer takes each result as it appears. A stalled result lets one
// more byte into the input register, after which the rx channel stalls too.
module sql_backend_message_parser
(
    input  wire logic        clk,
    input  wire logic        rst_n,

    input  wire logic        rx_valid,
    output logic             rx_stall,
    input  wire logic [7:0]  rx_byte,

    output logic             res_valid,
    input  wire logic        res_stall,
    output logic [7:0]       msg_type,
    output logic [3:0]       item_class,
    output logic [7:0]       data_byte,
    output logic [15:0]      column_index,
    output logic [7:0]       field_offset,
    output logic [7:0]       field_code,
    output logic             end_of_field,
    output logic             end_of_message,
    output logic             null_column,
    output logic             ready_idle,
    output logic             length_error
);
    import sbmp_pkg::*;

    logic       held_valid;
    logic [7:0] held_byte;
    logic       can_load;
    logic       step;
    result_t    step_result;
    result_t    res_data;

    // The parser consumes the held byte exactly when its result can be stored.
    assign step = held_valid && can_load;

    sbmp_in_reg u_in_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .rx_valid   (rx_valid),
        .rx_stall   (rx_stall),
        .rx_byte    (rx_byte),
        .take       (can_load),
        .held_valid (held_valid),
        .held_byte  (held_byte)
    );

    sbmp_parser u_parser
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (step),
        .in_byte (held_byte),
        .result  (step_result)
    );

    sbmp_out_reg u_out_reg
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .load_valid (held_valid),
        .load_data  (step_result),
        .can_load   (can_load),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // Result fields, one port each.
    assign msg_type       = res_data.msg_type;
    assign item_class     = res_data.item_class;
    assign data_byte      = res_data.data_byte;
    assign column_index   = res_data.column_index;
    assign field_offset   = res_data.field_offset;
    assign field_code     = res_data.field_code;
    assign end_of_field   = res_data.end_of_field;
    assign end_of_message = res_data.end_of_message;
    assign null_column    = res_data.null_column;
    assign ready_idle     = res_data.ready_idle;
    assign length_error   = res_data.length_error;

endmodule

`default_nettype wire

@@ hdl/sbmp_checker.sv @@
// Port-level checks for the backend message parser, bound to its top level.
// Depends on sbmp_pkg for class codes and type letters.
`default_nettype none

module sbmp_checker
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        res_valid,
    input  wire logic        res_stall,
    input  wire logic [7:0]  msg_type,
    input  wire logic [3:0]  item_class,
    input  wire logic        end_of_field,
    input  wire logic        end_of_message,
    input  wire logic        null_column,
    input  wire logic        ready_idle,
    input  wire logic        length_error
);
    import sbmp_pkg::*;

    logic res_take;
    logic expect_type_reg;

    assign res_take = res_valid && !res_stall;

    // Set after reset and after each delivered end of message.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            expect_type_reg <= 1'b1;
        end
        else if (res_take)
        begin
            expect_type_reg <= end_of_message;
        end
    end

    // A stalled result stays offered.
    a_res_held: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res_stall |=> res_valid)
        else $error("result withdrawn while stalled");

    // The request after a message end, or the first after reset, is a type byte.
    a_type_follows: assert property (@(posedge clk) disable iff (!rst_n)
        res_take && expect_type_reg |-> item_class == CLS_TYPE)
        else $error("message did not start with a type byte");

    // A short length ends the message on the length field.
    a_len_error: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && length_error |-> end_of_message && item_class == CLS_LENGTH)
        else $error("length error outside a final length byte");

    // A null column closes its column on a length byte of a data row.
    a_null_col: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && null_column |->
            end_of_field && item_class == CLS_COLLENGTH && msg_type == MSG_DATA_ROW)
        else $error("null column mark out of place");

    // The idle mark only appears on the status byte of a ready message.
    a_ready_idle: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && ready_idle |-> msg_type == MSG_READY && item_class == CLS_FIXED)
        else $error("idle mark outside a ready message");

endmodule

bind sql_backend_message_parser sbmp_checker u_sbmp_checker
(
    .clk            (clk),
    .rst_n          (rst_n),
    .res_valid      (res_valid),
    .res_stall      (res_stall),
    .msg_type       (msg_type),
    .item_class     (item_class),
    .end_of_field   (end_of_field),
    .end_of_message (end_of_message),
    .null_column    (null_column),
    .ready_idle     (ready_idle),
    .length_error   (length_error)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench for the backend message parser, built around a
// cycle-free model of the framing rules. Depends on sbmp_pkg (codes and the
// result record) and on the sql_backend_message_parser module.
module testbench;

    import sbmp_pkg::*;

    // Run length and pressure points.
    localparam int CYCLE_LIMIT  = 1_000_000;
    localparam int RANDOM_BYTES = 1900;
    localparam int HOLD_AT      = 700;   // accepted requests before the long result hold
    localparam int LONG_HOLD    = 300;   // cycles the result side refuses everything
    localparam int DRAIN_AT     = 1200;  // random bytes sent before the sender drains
    localparam int ATTR_SPAN    = 18;    // bytes in a row-description attribute block

    // Where the model's parse sits between two bytes.
    typedef enum logic [3:0] {
        AWAIT_TYPE,
        IN_LENGTH,
        IN_COLCOUNT,
        IN_COLLEN,
        IN_COLVALUE,
        IN_COLNAME,
        IN_ATTR,
        IN_FIELDCODE,
        IN_STRING,
        IN_FIXED,
        IN_REMAINDER,
        SKIPPING
    } frame_stage_t;

    // One row of the directed table. When typed is set, the listed flags and
    // the class are taken from the row instead of from the model.
    typedef struct packed {
        logic [7:0] rx;
        logic       typed;
        logic [3:0] cls;
        logic       eof;
        logic       eom;
        logic       nul;
        logic       idle;
        logic       lerr;
    } stim_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        rx_valid = 1'b0;
    logic        rx_stall;
    logic [7:0]  rx_byte = 8'h00;
    logic        res_valid;
    logic        res_stall = 1'b0;
    logic [7:0]  msg_type;
    logic [3:0]  item_class;
    logic [7:0]  data_byte;
    logic [15:0] column_index;
    logic [7:0]  field_offset;
    logic [7:0]  field_code;
    logic        end_of_field;
    logic        end_of_message;
    logic        null_column;
    logic        ready_idle;
    logic        length_error;

    // Model state of the parser, updated once per accepted request.
    logic [7:0]   cur_type;
    logic [31:0]  body_left;
    frame_stage_t stage;
    logic [31:0]  shift_acc;
    logic [31:0]  part_idx;
    logic [15:0]  cols_left;
    logic [15:0]  col_num;
    logic [7:0]   err_code;
    logic [7:0]   offset;

    // Classified results that the parser still owes us, oldest first.
    result_t     pending_results [$];
    logic [7:0]  body [$];
    logic [7:0]  outgoing [$];
    stim_row_t   directed_rows [27];
    stim_row_t   no_row;

    int          mismatches = 0;
    int          bytes_accepted = 0;
    int unsigned cycles_run = 0;
    bit          quiet = 1'b0;
    bit          hold_done = 1'b0;

    sql_backend_message_parser dut
    (
        .clk            (clk),
        .rst_n          (rst_n),
        .rx_valid       (rx_valid),
        .rx_stall       (rx_stall),
        .rx_byte        (rx_byte),
        .res_valid      (res_valid),
        .res_stall      (res_stall),
        .msg_type       (msg_type),
        .item_class     (item_class),
        .data_byte      (data_byte),
        .column_index   (column_index),
        .field_offset   (field_offset),
        .field_code     (field_code),
        .end_of_field   (end_of_field),
        .end_of_message (end_of_message),
        .null_column    (null_column),
        .ready_idle     (ready_idle),
        .length_error   (length_error)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Framing model
    // ------------------------------------------------------------------

    // Body layout of the simple message types: what the k-th field is.
    function automatic kind_t layout_of(input logic [7:0] t, input logic [31:0] k);
        kind_t kind;
        kind = KIND_NONE;
        case (t)
            MSG_NOTIFY:
                if (k == 0) kind = KIND_F4;
                else if (k <= 2) kind = KIND_STR;
            MSG_KEY_DATA:
                if (k <= 1) kind = KIND_F4;
            MSG_PARAM_STAT:
                if (k <= 1) kind = KIND_STR;
            MSG_CMD_DONE:
                if (k == 0) kind = KIND_STR;
            MSG_AUTH:
                if (k == 0) kind = KIND_F4;
                else if (k == 1) kind = KIND_REST;
            MSG_READY:
                if (k == 0) kind = KIND_F1;
            default:
                kind = KIND_NONE;
        endcase
        return kind;
    endfunction

    function automatic void start_part(input logic [31:0] k);
        part_idx = k;
        offset = 8'd0;
        case (layout_of(cur_type, k))
            KIND_F4, KIND_F1: stage = IN_FIXED;
            KIND_STR:         stage = IN_STRING;
            KIND_REST:        stage = IN_REMAINDER;
            default:          stage = SKIPPING;
        endcase
    endfunction

    function automatic void advance_column();
        cols_left = cols_left - 16'd1;
        col_num = col_num + 16'd1;
        offset = 8'd0;
        shift_acc = 32'd0;
        if (cols_left == 16'd0)
            stage = SKIPPING;
        else
            stage = (cur_type == MSG_DATA_ROW) ? IN_COLLEN : IN_COLNAME;
    endfunction

    function automatic void clear_frame();
        stage = AWAIT_TYPE;
        body_left = 32'd0;
        shift_acc = 32'd0;
        part_idx = 32'd0;
        cols_left = 16'd0;
        col_num = 16'd0;
        err_code = 8'd0;
        offset = 8'd0;
    endfunction

    // Classifies one byte and moves the model on; returns the result it owes.
    function automatic result_t parse_byte(input logic [7:0] b);
        result_t r;
        logic    ends_here;
        int      flen;
        r = '0;
        r.item_class = CLS_IGNORED;
        r.data_byte = b;
        ends_here = 1'b0;
        if (stage == AWAIT_TYPE)
        begin
            cur_type = b;
            clear_frame();
            stage = IN_LENGTH;
            r.item_class = CLS_TYPE;
        end
        else if (stage == IN_LENGTH)
        begin
            r.item_class = CLS_LENGTH;
            r.field_offset = offset;
            shift_acc = {shift_acc[23:0], b};
            if (offset >= 8'd3)
            begin
                if (shift_acc < HEADER_LENGTH)
                begin
                    r.length_error = 1'b1;
                    r.end_of_message = 1'b1;
                    clear_frame();
                end
                else if (shift_acc == HEADER_LENGTH)
                begin
                    // Header only: the message ends on its last length byte.
                    r.end_of_message = 1'b1;
                    clear_frame();
                end
                else
                begin
                    body_left = shift_acc - HEADER_LENGTH;
                    offset = 8'd0;
                    shift_acc = 32'd0;
                    err_code = 8'd0;
                    if (cur_type == MSG_DATA_ROW || cur_type == MSG_ROW_DESC)
                        stage = IN_COLCOUNT;
                    else if (cur_type == MSG_ERROR || cur_type == MSG_NOTICE)
                        stage = IN_FIELDCODE;
                    else
                        start_part(32'd0);
                end
            end
            else
                offset = offset + 8'd1;
        end
        else
        begin
            body_left = body_left - 32'd1;
            ends_here = (body_left == 32'd0);
            case (stage)
                IN_COLCOUNT:
                begin
                    r.item_class = CLS_COLCOUNT;
                    r.field_offset = offset;
                    shift_acc = {shift_acc[23:0], b};
                    if (offset >= 8'd1)
                    begin
                        r.end_of_field = 1'b1;
                        cols_left = shift_acc[15:0];
                        col_num = 16'd0;
                        offset = 8'd0;
                        shift_acc = 32'd0;
                        if (cols_left == 16'd0)
                            stage = SKIPPING;
                        else
                            stage = (cur_type == MSG_DATA_ROW) ? IN_COLLEN : IN_COLNAME;
                    end
                    else
                        offset = offset + 8'd1;
                end
                IN_COLLEN:
                begin
                    r.item_class = CLS_COLLENGTH;
                    r.column_index = col_num;
                    r.field_offset = offset;
                    shift_acc = {shift_acc[23:0], b};
                    if (offset >= 8'd3)
                    begin
                        if (shift_acc == NULL_LENGTH)
                        begin
                            r.null_column = 1'b1;
                            r.end_of_field = 1'b1;
                            advance_column();
                        end
                        else if (shift_acc == 32'd0)
                        begin
                            r.end_of_field = 1'b1;
                            advance_column();
                        end
                        else
                        begin
                            part_idx = shift_acc;
                            stage = IN_COLVALUE;
                        end
                    end
                    else
                        offset = offset + 8'd1;
                end
                IN_COLVALUE:
                begin
                    r.item_class = CLS_COLVALUE;
                    r.column_index = col_num;
                    part_idx = part_idx - 32'd1;
                    if (part_idx == 32'd0)
                    begin
                        r.end_of_field = 1'b1;
                        advance_column();
                    end
                end
                IN_COLNAME:
                begin
                    r.item_class = CLS_COLNAME;
                    r.column_index = col_num;
                    if (b == 8'h00)
                    begin
                        r.end_of_field = 1'b1;
                        offset = 8'd0;
                        stage = IN_ATTR;
                    end
                end
                IN_ATTR:
                begin
                    r.item_class = CLS_COLATTR;
                    r.column_index = col_num;
                    r.field_offset = offset;
                    if (int'(offset) + 1 >= ATTR_SPAN)
                    begin
                        r.end_of_field = 1'b1;
                        advance_column();
                    end
                    else
                        offset = offset + 8'd1;
                end
                IN_FIELDCODE:
                begin
                    r.item_class = CLS_FIELDCODE;
                    r.field_code = b;
                    err_code = b;
                    stage = (b == 8'h00) ? SKIPPING : IN_STRING;
                end
                IN_STRING:
                begin
                    r.item_class = CLS_STRING;
                    r.field_code = err_code;
                    if (b == 8'h00)
                    begin
                        r.end_of_field = 1'b1;
                        if (cur_type == MSG_ERROR || cur_type == MSG_NOTICE)
                            stage = IN_FIELDCODE;
                        else
                            start_part(part_idx + 32'd1);
                    end
                end
                IN_FIXED:
                begin
                    flen = (layout_of(cur_type, part_idx) == KIND_F1) ? 1 : 4;
                    r.item_class = CLS_FIXED;
                    r.field_offset = offset;
                    if (cur_type == MSG_READY && b == STATUS_IDLE)
                        r.ready_idle = 1'b1;
                    if (int'(offset) + 1 >= flen)
                    begin
                        r.end_of_field = 1'b1;
                        start_part(part_idx + 32'd1);
                    end
                    else
                        offset = offset + 8'd1;
                end
                IN_REMAINDER:
                begin
                    // The offset saturates; the field closes only with the message.
                    r.item_class = CLS_FIXED;
                    r.field_offset = offset;
                    if (offset != OFFSET_MAX)
                        offset = offset + 8'd1;
                    if (ends_here)
                        r.end_of_field = 1'b1;
                end
                default:
                    r.item_class = CLS_IGNORED;
            endcase
            if (ends_here)
            begin
                r.end_of_message = 1'b1;
                clear_frame();
            end
        end
        r.msg_type = cur_type;
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Message generator
    // ------------------------------------------------------------------

    // Gap length for either side: mostly none, sometimes short, rarely long.
    function automatic int idle_span();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 60) return 0;
        if (pick < 90) return $urandom_range(1, 3);
        if (pick < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic void put_random(input int n);
        repeat (n) body.push_back(8'($urandom_range(0, 255)));
    endfunction

    function automatic void put_word(input logic [31:0] w);
        body.push_back(w[31:24]);
        body.push_back(w[23:16]);
        body.push_back(w[15:8]);
        body.push_back(w[7:0]);
    endfunction

    // Zero-terminated string with random nonzero content.
    function automatic void put_string();
        repeat ($urandom_range(0, 5)) body.push_back(8'($urandom_range(1, 255)));
        body.push_back(8'h00);
    endfunction

    // Builds one message into outgoing. Most messages follow their layout
    // with random content; a share carries a bad, header-only or cut length,
    // trailing junk, or a type the parser does not know.
    function automatic void build_message();
        logic [7:0]  t;
        logic [31:0] len;
        logic [31:0] clen;
        logic [15:0] ncount;
        int          ncols;
        int          pick;
        int          cut;
        body.delete();
        pick = $urandom_range(0, 11);
        case (pick)
            0: t = MSG_DATA_ROW;
            1: t = MSG_ROW_DESC;
            2: t = MSG_ERROR;
            3: t = MSG_NOTICE;
            4: t = MSG_NOTIFY;
            5: t = MSG_CMD_DONE;
            6: t = MSG_READY;
            7: t = MSG_KEY_DATA;
            8: t = MSG_AUTH;
            9: t = MSG_PARAM_STAT;
            default: t = 8'($urandom_range(0, 255));
        endcase
        if (pick >= 10)
            put_random($urandom_range(0, 6));
        else if (t == MSG_DATA_ROW || t == MSG_ROW_DESC)
        begin
            ncols = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 4);
            // Now and then the column count disagrees with the columns sent.
            ncount = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 65535))
                                                   : 16'(ncols);
            body.push_back(ncount[15:8]);
            body.push_back(ncount[7:0]);
            repeat (ncols)
            begin
                if (t == MSG_ROW_DESC)
                begin
                    put_string();
                    put_random(ATTR_SPAN);
                end
                else
                begin
                    pick = $urandom_range(0, 9);
                    if (pick == 0)
                        put_word(NULL_LENGTH);
                    else if (pick == 1)
                        put_word(32'd0);
                    else if (pick == 2)
                    begin
                        // Column longer than the rest of the message.
                        clen = $urandom();
                        clen[8] = 1'b1;
                        clen[0] = 1'b0;
                        put_word(clen);
                        put_random(3);
                    end
                    else
                    begin
                        clen = $urandom_range(1, 6);
                        put_word(clen);
                        put_random(int'(clen));
                    end
                end
            end
        end
        else if (t == MSG_ERROR || t == MSG_NOTICE)
        begin
            repeat ($urandom_range(0, 3))
            begin
                body.push_back(8'($urandom_range(1, 255)));
                put_string();
            end
            body.push_back(8'h00);
        end
        else if (t == MSG_NOTIFY)
        begin
            put_random(4);
            put_string();
            put_string();
        end
        else if (t == MSG_KEY_DATA)
            put_random(8);
        else if (t == MSG_PARAM_STAT)
        begin
            put_string();
            put_string();
        end
        else if (t == MSG_CMD_DONE)
            put_string();
        else if (t == MSG_AUTH)
        begin
            put_random(4);
            // A few long remainders walk the offset into saturation.
            put_random(($urandom_range(0, 40) == 0) ? $urandom_range(256, 300)
                                                    : $urandom_range(0, 8));
        end
        else
            body.push_back(($urandom_range(0, 1) == 0) ? STATUS_IDLE
                                                       : 8'($urandom_range(0, 255)));

        if ($urandom_range(0, 7) == 0)
            put_random($urandom_range(1, 3));

        pick = $urandom_range(0, 99);
        if (pick < 5)
        begin
            body.delete();
            len = $urandom_range(0, 3);
        end
        else
        begin
            if (pick < 9)
                body.delete();
            else if (pick < 18 && body.size() > 0)
            begin
                cut = $urandom_range(0, body.size() - 1);
                while (body.size() > cut) void'(body.pop_back());
            end
            len = body.size() + HEADER_LENGTH;
        end

        outgoing.delete();
        outgoing.push_back(t);
        outgoing.push_back(len[31:24]);
        outgoing.push_back(len[23:16]);
        outgoing.push_back(len[15:8]);
        outgoing.push_back(len[7:0]);
        foreach (body[i]) outgoing.push_back(body[i]);
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offers one byte and holds it until the parser takes it, then records
    // what it owes. Valid stays high across back-to-back requests, so it is
    // never lowered and raised within one time step.
    task automatic send_byte(input logic [7:0] b, input stim_row_t row);
        result_t r;
        int      gap;
        rx_valid <= 1'b1;
        rx_byte <= b;
        @(posedge clk);
        while (rx_stall) @(posedge clk);
        r = parse_byte(b);
        if (row.typed)
        begin
            r.item_class = row.cls;
            r.end_of_field = row.eof;
            r.end_of_message = row.eom;
            r.null_column = row.nul;
            r.ready_idle = row.idle;
            r.length_error = row.lerr;
        end
        pending_results.push_back(r);
        bytes_accepted++;
        gap = quiet ? 0 : idle_span();
        if (gap > 0)
        begin
            rx_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    initial
    begin : stimulus
        int random_sent;
        bit drained;
        random_sent = 0;
        drained = 1'b0;
        no_row = '0;
        cur_type = 8'h00;
        clear_frame();

        // Directed bytes: a short length on an unknown type, a header-only
        // ready message, a ready message reporting idle, and a data row with
        // one null column, where the stream's zero and all-ones bytes sit.
        directed_rows = '{
            '{8'h58,          1'b1, CLS_TYPE,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h02,          1'b1, CLS_LENGTH,    1'b0, 1'b1, 1'b0, 1'b0, 1'b1},
            '{MSG_READY,      1'b1, CLS_TYPE,      1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h04,          1'b1, CLS_LENGTH,    1'b0, 1'b1, 1'b0, 1'b0, 1'b0},
            '{MSG_READY,      1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h05,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{STATUS_IDLE,    1'b1, CLS_FIXED,     1'b1, 1'b1, 1'b0, 1'b1, 1'b0},
            '{MSG_DATA_ROW,   1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h0A,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h00,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'h01,          1'b1, CLS_COLCOUNT,  1'b1, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'hFF,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'hFF,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'hFF,          1'b0, CLS_IGNORED,   1'b0, 1'b0, 1'b0, 1'b0, 1'b0},
            '{8'hFF,          1'b1, CLS_COLLENGTH, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0}
        };

        // Reset is held and then released on a rising edge.
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i]) send_byte(directed_rows[i].rx, directed_rows[i]);

        while (random_sent < RANDOM_BYTES)
        begin
            // Once, the sender stops until every owed result has come back,
            // so the parser runs completely dry mid-stream.
            if (!drained && random_sent >= DRAIN_AT)
            begin
                drained = 1'b1;
                rx_valid <= 1'b0;
                @(posedge clk);
                while (pending_results.size() != 0) @(posedge clk);
            end
            build_message();
            // About one message in four goes out back to back.
            quiet = ($urandom_range(0, 3) == 0);
            foreach (outgoing[i]) send_byte(outgoing[i], no_row);
            random_sent += outgoing.size();
        end

        rx_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        // The wait after the drain catches any result the parser emits beyond the stream.
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("[sql_backend_message_parser] OK");
        else
            $display("[sql_backend_message_parser] ERROR");
        $finish;
    end

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------

    // Alternates free stretches with stalls of random length. Once, well into
    // the run, it refuses results for a long stretch while requests keep
    // coming, so the parser fills up and stalls its own input.
    initial
    begin : result_side
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (!hold_done && bytes_accepted >= HOLD_AT)
            begin
                hold_done = 1'b1;
                res_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge clk);
            end
            res_stall <= 1'b0;
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(40, 150)
                                                : $urandom_range(1, 12)) @(posedge clk);
            res_stall <= 1'b1;
            repeat (idle_span()) @(posedge clk);
        end
    end

    function automatic void check_field(input string name, input logic [15:0] want,
                                        input logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 'h%0h, got 'h%0h", name, want, got);
            mismatches++;
        end
    endfunction

    // Every taken result is matched against the oldest owed one. Values are
    // read as they stood just before the edge, so event order does not matter.
    always @(posedge clk)
    begin : result_check
        result_t want;
        if (rst_n && res_valid && !res_stall)
        begin
            if (pending_results.size() == 0)
            begin
                $error("result taken with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = pending_results.pop_front();
                check_field("msg_type", 16'(want.msg_type), 16'(msg_type));
                check_field("item_class", 16'(want.item_class), 16'(item_class));
                check_field("data_byte", 16'(want.data_byte), 16'(data_byte));
                check_field("column_index", want.column_index, column_index);
                check_field("field_offset", 16'(want.field_offset), 16'(field_offset));
                check_field("field_code", 16'(want.field_code), 16'(field_code));
                check_field("end_of_field", 16'(want.end_of_field), 16'(end_of_field));
                check_field("end_of_message", 16'(want.end_of_message),
                            16'(end_of_message));
                check_field("null_column", 16'(want.null_column), 16'(null_column));
                check_field("ready_idle", 16'(want.ready_idle), 16'(ready_idle));
                check_field("length_error", 16'(want.length_error), 16'(length_error));
            end
        end
    end

    // Watchdog: a hung handshake ends the run as a failure.
    always @(posedge clk)
    begin
        cycles_run++;
        if (cycles_run >= CYCLE_LIMIT)
        begin
            $display("[sql_backend_message_parser] ERROR");
            $finish;
        end
    end

endmodule
